// ===== design/mafr_pkg.sv =====
// Shared types, codes and constants of the mutex arbiter with a waiter queue.
`default_nettype none

package mafr_pkg;

    // Default sizes handed to the top level.
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_REQUESTERS  = 16;

    // LFSR that drives the random waiter choice (Galois, x^16+x^14+x^13+x^11+1).
    localparam int              LFSR_W     = 16;
    localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;
    localparam logic [LFSR_W-1:0] SEED_RESET = 16'h0001;

    // Configuration port geometry and register indexes (paddr bit 2).
    localparam int   APB_AW     = 3;
    localparam int   APB_DW     = 32;
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_SEED   = 1'b1;

    // Request kinds carried in the input tuser bit.
    localparam logic KIND_LOCK   = 1'b0;
    localparam logic KIND_UNLOCK = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_ACQUIRED  = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_RELEASED  = 3'd2,
        ST_NOT_OWNER = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    set_res;
        t_status res_status;
        logic    acquire;
        logic    enqueue;
        logic    release_lock;
        logic    idx_clear;
        logic    div_start;
        logic    div_step;
        logic    pick_div;
        logic    take;
        logic    rd_next;
        logic    sh_write;
        logic    pop_head;
        logic    pop_tail;
        logic    load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic unlock;
        logic held;
        logic owner_match;
        logic count_zero;
        logic queue_full;
        logic policy_random;
        logic div_done;
        logic pick_zero;
        logic shift_first;
        logic shift_more;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== design/mafr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module mafr_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/mafr_ctrl.sv =====
// Controller state machine of the mutex arbiter: sequences one request at a time.
`default_nettype none

module mafr_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  wire mafr_pkg::t_stat i_stat,
    output mafr_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_DIV,
        S_RD_PICK,
        S_TAKE,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   n_ready;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_status = mafr_pkg::ST_ACQUIRED;
        case (r_state)
            S_IDLE: begin
                // Only a transaction that is actually accepted is captured.
                if (i_s_tvalid && r_ready) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.set_res = 1'b1;
                n_state       = S_DONE;
                if (!i_stat.unlock) begin
                    if (!i_stat.held) begin
                        o_cmd.acquire    = 1'b1;
                        o_cmd.res_status = mafr_pkg::ST_ACQUIRED;
                    end else if (!i_stat.queue_full) begin
                        o_cmd.enqueue    = 1'b1;
                        o_cmd.res_status = mafr_pkg::ST_QUEUED;
                    end else begin
                        o_cmd.res_status = mafr_pkg::ST_FULL;
                    end
                end else if (!i_stat.held || !i_stat.owner_match) begin
                    o_cmd.res_status = mafr_pkg::ST_NOT_OWNER;
                end else begin
                    o_cmd.res_status = mafr_pkg::ST_RELEASED;
                    if (i_stat.count_zero) begin
                        o_cmd.release_lock = 1'b1;
                    end else if (i_stat.policy_random) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end else begin
                        o_cmd.idx_clear = 1'b1;
                        n_state         = S_RD_PICK;
                    end
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.pick_div = 1'b1;
                    n_state        = S_RD_PICK;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_RD_PICK: begin
                n_state = S_TAKE;
            end
            S_TAKE: begin
                o_cmd.take = 1'b1;
                if (i_stat.pick_zero) begin
                    o_cmd.pop_head = 1'b1;
                    n_state        = S_DONE;
                end else if (i_stat.shift_first) begin
                    n_state = S_SH_RD;
                end else begin
                    o_cmd.pop_tail = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_SH_RD: begin
                o_cmd.rd_next = 1'b1;
                n_state       = S_SH_WR;
            end
            S_SH_WR: begin
                o_cmd.sh_write = 1'b1;
                if (i_stat.shift_more) begin
                    n_state = S_SH_RD;
                end else begin
                    o_cmd.pop_tail = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_ready = (n_state == S_IDLE);
    end

    // State register and registered ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_s_tready = r_ready && (r_state == S_IDLE);

endmodule

`default_nettype wire

// ===== design/mafr_dpath.sv =====
// Datapath of the mutex arbiter: ownership, waiter queue, LFSR, divider, result.
`default_nettype none

module mafr_dpath #(
    parameter int QUEUE_DEPTH = mafr_pkg::DEF_QUEUE_DEPTH,
    parameter int REQUESTERS  = mafr_pkg::DEF_REQUESTERS,
    localparam int ID_W  = $clog2(REQUESTERS),
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mafr_pkg::t_cmd                i_cmd,
    output mafr_pkg::t_stat                    o_stat,
    input  wire logic                          i_req_kind,
    input  wire logic [ID_W-1:0]               i_req_id,
    input  wire logic                          i_policy,
    input  wire logic                          i_seed_load,
    input  wire logic [mafr_pkg::LFSR_W-1:0]   i_seed,
    input  wire logic                          i_m_tready,
    output logic                               o_valid,
    output logic [2:0]                         o_status,
    output logic                               o_granted,
    output logic [ID_W-1:0]                    o_grant_id,
    output logic                               o_owner_valid,
    output logic [CNT_W-1:0]                   o_count
);

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int DCNT_W = $clog2(mafr_pkg::LFSR_W + 1);
    localparam logic [IDX_W:0]   DEPTH_P = (IDX_W + 1)'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_P  = IDX_W'(QUEUE_DEPTH - 1);

    // Control state.
    logic                        r_held;
    logic [ID_W-1:0]             r_owner;
    logic [IDX_W-1:0]            r_head;
    logic [CNT_W-1:0]            r_count;
    logic [mafr_pkg::LFSR_W-1:0] r_lfsr;
    logic                        r_out_valid;

    // Payload registers.
    logic                        r_kind;
    logic [ID_W-1:0]             r_req_id;
    logic [IDX_W-1:0]            r_idx;
    logic [CNT_W-1:0]            r_rem;
    logic [mafr_pkg::LFSR_W-1:0] r_dvd;
    logic [DCNT_W-1:0]           r_dcnt;
    mafr_pkg::t_status           r_res_status;
    logic                        r_res_granted;
    logic [ID_W-1:0]             r_res_gid;
    logic [2:0]                  r_o_status;
    logic                        r_o_granted;
    logic [ID_W-1:0]             r_o_gid;
    logic                        r_o_held;
    logic [CNT_W-1:0]            r_o_count;

    // Queue memory signals.
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [ID_W-1:0]  w_wdata;
    logic [IDX_W-1:0] w_raddr;
    logic [ID_W-1:0]  w_rdata;
    logic [IDX_W-1:0] w_idx_p1;
    logic [IDX_W-1:0] w_head_next;

    // Divider step signals.
    logic [CNT_W:0]   w_trial;
    logic [CNT_W:0]   w_diff;
    logic [CNT_W-1:0] w_rem_next;

    // Logical queue position to memory address, wrapping at the queue depth.
    function automatic logic [IDX_W-1:0] f_phys(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_P) begin
            sum = sum - DEPTH_P;
        end
        return sum[IDX_W-1:0];
    endfunction

    // One Galois LFSR step.
    function automatic logic [mafr_pkg::LFSR_W-1:0] f_lfsr_next(
        input logic [mafr_pkg::LFSR_W-1:0] cur);
        logic [mafr_pkg::LFSR_W-1:0] nxt;
        nxt = {1'b0, cur[mafr_pkg::LFSR_W-1:1]};
        if (cur[0]) begin
            nxt = nxt ^ mafr_pkg::LFSR_TAPS;
        end
        return nxt;
    endfunction

    assign w_idx_p1    = r_idx + IDX_W'(1);
    assign w_head_next = (r_head == LAST_P) ? '0 : r_head + IDX_W'(1);

    // Memory ports: append at the tail, or move one entry down during a shift.
    assign w_we    = i_cmd.enqueue || i_cmd.sh_write;
    assign w_waddr = i_cmd.enqueue ? f_phys(r_head, r_count[IDX_W-1:0])
                                   : f_phys(r_head, r_idx);
    assign w_wdata = i_cmd.enqueue ? r_req_id : w_rdata;
    assign w_raddr = f_phys(r_head, i_cmd.rd_next ? w_idx_p1 : r_idx);

    mafr_ram #(
        .WIDTH (ID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Restoring remainder step: one dividend bit per cycle.
    assign w_trial    = {r_rem, r_dvd[mafr_pkg::LFSR_W-1]};
    assign w_diff     = w_trial - {1'b0, r_count};
    assign w_rem_next = (w_trial >= {1'b0, r_count}) ? w_diff[CNT_W-1:0]
                                                     : w_trial[CNT_W-1:0];

    // Status toward the controller.
    always_comb begin
        o_stat.unlock        = (r_kind == mafr_pkg::KIND_UNLOCK);
        o_stat.held          = r_held;
        o_stat.owner_match   = (r_owner == r_req_id);
        o_stat.count_zero    = (r_count == '0);
        o_stat.queue_full    = (r_count == CNT_W'(QUEUE_DEPTH));
        o_stat.policy_random = i_policy;
        o_stat.div_done      = (r_dcnt == DCNT_W'(mafr_pkg::LFSR_W));
        o_stat.pick_zero     = (r_idx == '0);
        o_stat.shift_first   = ((CNT_W + 1)'(r_idx) + (CNT_W + 1)'(1))
                               < (CNT_W + 1)'(r_count);
        o_stat.shift_more    = ((CNT_W + 1)'(r_idx) + (CNT_W + 1)'(2))
                               < (CNT_W + 1)'(r_count);
        o_stat.out_free      = !r_out_valid || i_m_tready;
    end

    // Control state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= 1'b0;
            r_owner     <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_lfsr      <= mafr_pkg::SEED_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.acquire) begin
                r_held  <= 1'b1;
                r_owner <= r_req_id;
            end
            if (i_cmd.release_lock) begin
                r_held  <= 1'b0;
                r_owner <= '0;
            end
            if (i_cmd.take) begin
                r_owner <= w_rdata;
            end
            if (i_cmd.enqueue) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.pop_head) begin
                r_head  <= w_head_next;
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.pop_tail) begin
                r_count <= r_count - CNT_W'(1);
            end
            // A seed write loads the LFSR; a zero seed would lock it up.
            if (i_seed_load) begin
                r_lfsr <= (i_seed == '0) ? mafr_pkg::SEED_RESET : i_seed;
            end else if (i_cmd.div_start) begin
                r_lfsr <= f_lfsr_next(r_lfsr);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request, divider, index and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind        <= i_req_kind;
            r_req_id      <= i_req_id;
            r_res_granted <= 1'b0;
            r_res_gid     <= '0;
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_status;
        end
        if (i_cmd.acquire) begin
            r_res_granted <= 1'b1;
            r_res_gid     <= r_req_id;
        end
        if (i_cmd.take) begin
            r_res_granted <= 1'b1;
            r_res_gid     <= w_rdata;
        end
        if (i_cmd.div_start) begin
            r_dvd  <= f_lfsr_next(r_lfsr);
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd  <= {r_dvd[mafr_pkg::LFSR_W-2:0], 1'b0};
            r_rem  <= w_rem_next;
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end
        if (i_cmd.idx_clear) begin
            r_idx <= '0;
        end
        if (i_cmd.pick_div) begin
            r_idx <= r_rem[IDX_W-1:0];
        end
        if (i_cmd.sh_write) begin
            r_idx <= w_idx_p1;
        end
        if (i_cmd.load_out) begin
            r_o_status  <= r_res_status;
            r_o_granted <= r_res_granted;
            r_o_gid     <= r_res_gid;
            r_o_held    <= r_held;
            r_o_count   <= r_count;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_o_status;
    assign o_granted     = r_o_granted;
    assign o_grant_id    = r_o_gid;
    assign o_owner_valid = r_o_held;
    assign o_count       = r_o_count;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("Waiter count exceeds the queue depth.");

    a_free_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_held |-> (r_count == '0))
        else $error("Waiters are queued on a free mutex.");

    a_lfsr_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != '0)
        else $error("LFSR reached the all-zero lockup state.");

    a_pick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pick_div |-> ((r_count != '0) && (r_rem < r_count)))
        else $error("Random pick lies outside the waiter queue.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_m_tready))
        else $error("A pending result was overwritten.");
`endif

endmodule

`default_nettype wire

// ===== design/mutex_arbiter_fifo_random.sv =====
// Top level of the mutex arbiter with a FIFO or random waiter queue.
//
// Each input transaction is a lock or unlock request (tuser: kind, 0 lock, 1 unlock;
// tdata: requester id) and yields exactly one result transaction. Requests are
// handled one at a time by a controller that steps a queue memory with a registered
// read port; a new request is taken once the previous one has been placed in the
// output register. An unlock with waiters hands the mutex to the oldest one under
// the FIFO policy. Under the random policy the pick index is the advanced LFSR
// modulo the waiter count, worked out by a one-bit-per-cycle remainder unit, and
// every waiter behind the picked one is moved down by one memory read and one
// write. Registers: policy at byte address 0, seed at 4 (a seed write also
// reloads the LFSR, zero loads one). No clearing pass runs after reset.
`default_nettype none

module mutex_arbiter_fifo_random #(
    parameter int QUEUE_DEPTH = mafr_pkg::DEF_QUEUE_DEPTH,
    parameter int REQUESTERS  = mafr_pkg::DEF_REQUESTERS,
    localparam int ID_W  = $clog2(REQUESTERS),
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
    localparam int IN_W  = ((ID_W + 7) / 8) * 8,
    localparam int OUT_W = ((ID_W + CNT_W + 2 + 7) / 8) * 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Request stream.
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [IN_W-1:0]             i_s_tdata,  // requester
    input  wire logic                        i_s_tuser,  // kind
    // Result stream.
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output logic [OUT_W-1:0]                 o_m_tdata,  // granted, grant_id,
                                                         // owner_valid, waiting_count
    output logic [2:0]                       o_m_tuser,  // status
    // Configuration port.
    input  wire logic                        i_psel,
    input  wire logic                        i_penable,
    input  wire logic                        i_pwrite,
    input  wire logic [mafr_pkg::APB_AW-1:0] i_paddr,
    input  wire logic [mafr_pkg::APB_DW-1:0] i_pwdata,
    output logic      [mafr_pkg::APB_DW-1:0] o_prdata,
    output logic                             o_pready
);

    logic                        r_policy;
    logic [mafr_pkg::LFSR_W-1:0] r_seed;
    logic                        w_cfg_wr;
    logic                        w_seed_load;
    mafr_pkg::t_cmd              w_cmd;
    mafr_pkg::t_stat             w_stat;
    logic [2:0]                  w_status;
    logic                        w_granted;
    logic [ID_W-1:0]             w_grant_id;
    logic                        w_owner_valid;
    logic [CNT_W-1:0]            w_count;

    // Configuration registers; the byte offset bits of paddr are ignored.
    assign o_pready    = 1'b1;
    assign w_cfg_wr    = i_psel && i_penable && i_pwrite && o_pready;
    assign w_seed_load = w_cfg_wr && (i_paddr[2] == mafr_pkg::REG_SEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= 1'b0;
            r_seed   <= mafr_pkg::SEED_RESET;
        end else if (w_cfg_wr) begin
            if (i_paddr[2] == mafr_pkg::REG_POLICY) begin
                r_policy <= i_pwdata[0];
            end else begin
                r_seed <= i_pwdata[mafr_pkg::LFSR_W-1:0];
            end
        end
    end

    // Register read-back.
    assign o_prdata = (i_paddr[2] == mafr_pkg::REG_SEED) ? mafr_pkg::APB_DW'(r_seed)
                                                         : mafr_pkg::APB_DW'(r_policy);

    mafr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mafr_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .REQUESTERS  (REQUESTERS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_req_kind    (i_s_tuser),
        .i_req_id      (i_s_tdata[ID_W-1:0]),
        .i_policy      (r_policy),
        .i_seed_load   (w_seed_load),
        .i_seed        (i_pwdata[mafr_pkg::LFSR_W-1:0]),
        .i_m_tready    (i_m_tready),
        .o_valid       (o_m_tvalid),
        .o_status      (w_status),
        .o_granted     (w_granted),
        .o_grant_id    (w_grant_id),
        .o_owner_valid (w_owner_valid),
        .o_count       (w_count)
    );

    // Result packing, first field in the lowest bits.
    assign o_m_tdata = OUT_W'({w_count, w_owner_valid, w_grant_id, w_granted});
    assign o_m_tuser = w_status;

endmodule

`default_nettype wire

// ===== sim/tb_mutex_arbiter_fifo_random.sv =====
// Self-checking testbench for the mutex arbiter with a FIFO or random waiter queue.
`timescale 1ns / 1ps

module tb_mutex_arbiter_fifo_random;

    localparam int WAIT_SLOTS  = 16;
    localparam int SETTLE      = 60;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 222;
    localparam int PLAN_ROWS   = 25;
    localparam int EXP_SLOTS   = 8;

    // Expected content of one result transaction.
    typedef struct packed {
        mafr_pkg::t_status status;
        logic              granted;
        logic [3:0]        grant_id;
        logic              owner_valid;
        logic [4:0]        waiting_count;
    } t_grant;

    // One row of the directed stimulus table.
    typedef struct {
        logic       kind;
        logic [3:0] who;
        bit         typed;
        t_grant     want;
    } t_plan_row;

    // One register setting for a random phase.
    typedef struct {
        logic        policy;
        bit          load_seed;
        logic [15:0] seed;
    } t_setup;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // requester
    logic        i_s_tuser;   // kind
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // granted, grant_id, owner_valid, waiting_count
    logic [2:0]  o_m_tuser;   // status
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [mafr_pkg::APB_AW-1:0] i_paddr;
    logic [mafr_pkg::APB_DW-1:0] i_pwdata;
    logic [mafr_pkg::APB_DW-1:0] o_prdata;
    logic        o_pready;

    // Arbiter state as predicted by the testbench.
    logic        arb_policy;
    logic [15:0] arb_lfsr;
    logic        arb_held;
    logic [3:0]  arb_owner;
    logic [3:0]  arb_waiters [WAIT_SLOTS];
    int          arb_count;

    // Expected results waiting for their transaction, kept in a small ring.
    t_grant    exp_ring [EXP_SLOTS];
    int        exp_wr;
    int        exp_rd;
    t_plan_row plan [PLAN_ROWS];
    t_setup    setups [PHASES];
    int        mismatches;
    int        results_seen;
    int        requests_sent;
    int        status_seen [5];
    int        sink_wait;
    bit        calm;

    mutex_arbiter_fifo_random dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    // Free-running clock with a 10 ns period.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Prints one mismatch line, up to a cap, and counts every mismatch.
    task automatic report_mismatch(input string field, input int got, input int want);
        if (mismatches < 30) begin
            $display("result %0d: %s is %0d, expected %0d", results_seen, field, got, want);
        end
        mismatches++;
    endtask

    // Applies one request to the predicted state and returns the result it causes.
    task automatic arbitrate(input logic kind, input logic [3:0] who, output t_grant r);
        int         pick;
        logic [3:0] next_owner;
        logic       lsb;
        r = '0;
        if (kind == mafr_pkg::KIND_LOCK) begin
            if (!arb_held) begin
                arb_held   = 1'b1;
                arb_owner  = who;
                r.status   = mafr_pkg::ST_ACQUIRED;
                r.granted  = 1'b1;
                r.grant_id = who;
            end else if (arb_count < WAIT_SLOTS) begin
                arb_waiters[arb_count] = who;
                arb_count++;
                r.status = mafr_pkg::ST_QUEUED;
            end else begin
                r.status = mafr_pkg::ST_FULL;
            end
        end else if (!arb_held || arb_owner != who) begin
            r.status = mafr_pkg::ST_NOT_OWNER;
        end else begin
            r.status = mafr_pkg::ST_RELEASED;
            if (arb_count > 0) begin
                // The random policy steps the LFSR first and picks with the new value.
                pick = 0;
                if (arb_policy) begin
                    lsb      = arb_lfsr[0];
                    arb_lfsr = arb_lfsr >> 1;
                    if (lsb) begin
                        arb_lfsr = arb_lfsr ^ mafr_pkg::LFSR_TAPS;
                    end
                    pick = int'(arb_lfsr) % arb_count;
                end
                next_owner = arb_waiters[pick];
                for (int i = pick; i + 1 < arb_count; i++) begin
                    arb_waiters[i] = arb_waiters[i + 1];
                end
                arb_count--;
                arb_owner  = next_owner;
                r.granted  = 1'b1;
                r.grant_id = next_owner;
            end else begin
                arb_held  = 1'b0;
                arb_owner = 4'd0;
            end
        end
        r.owner_valid   = arb_held;
        r.waiting_count = arb_count[4:0];
    endtask

    // Sends one request after a random gap, none in calm phases, and records what it should produce.
    task automatic send_req(input logic kind, input logic [3:0] who, input bit typed,
                            input t_grant want);
        int     gap;
        t_grant r;
        gap = calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {4'd0, who};
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
        arbitrate(kind, who, r);
        exp_ring[exp_wr % EXP_SLOTS] = typed ? want : r;
        exp_wr++;
        requests_sent++;
    endtask

    // Holds the request stream until every outstanding result has come back.
    task automatic wait_idle;
        i_s_tvalid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Writes one register through a setup phase and an access phase.
    task automatic write_reg(input logic reg_idx, input logic [31:0] value);
        @(posedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {reg_idx, 2'b00};
        i_pwdata  <= value;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        if (reg_idx == mafr_pkg::REG_POLICY) begin
            arb_policy = value[0];
        end else begin
            // A zero seed would freeze the LFSR, so it loads one instead.
            arb_lfsr = (value[15:0] == 16'd0) ? 16'd1 : value[15:0];
        end
    endtask

    // Result sink: a random stall after every transaction, none in calm phases.
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) begin
            sink_wait = calm ? 0 : $urandom_range(0, 18);
        end else if (sink_wait > 0) begin
            sink_wait--;
        end
        i_m_tready <= (sink_wait == 0);
    end

    // Compares each result transaction with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_grant want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (exp_wr == exp_rd) begin
                report_mismatch("result with no request outstanding, status",
                                int'(o_m_tuser), 0);
            end else begin
                want = exp_ring[exp_rd % EXP_SLOTS];
                if (o_m_tuser != want.status) begin
                    report_mismatch("status", int'(o_m_tuser), int'(want.status));
                end
                if (o_m_tdata[0] != want.granted) begin
                    report_mismatch("granted", int'(o_m_tdata[0]), int'(want.granted));
                end
                if (o_m_tdata[4:1] != want.grant_id) begin
                    report_mismatch("grant_id", int'(o_m_tdata[4:1]), int'(want.grant_id));
                end
                if (o_m_tdata[5] != want.owner_valid) begin
                    report_mismatch("owner_valid", int'(o_m_tdata[5]),
                                    int'(want.owner_valid));
                end
                if (o_m_tdata[10:6] != want.waiting_count) begin
                    report_mismatch("waiting_count", int'(o_m_tdata[10:6]),
                                    int'(want.waiting_count));
                end
                if (want.status <= mafr_pkg::ST_FULL) begin
                    status_seen[want.status]++;
                end
                exp_rd++;
            end
            results_seen++;
        end
    end

    // Stimulus: reset, the directed table, then random phases under several settings.
    initial begin : stimulus
        int         lock_pct;
        logic       kind;
        logic [3:0] who;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = 1'b0;
        i_m_tready = 1'b0;
        i_psel     = 1'b0;
        i_penable  = 1'b0;
        i_pwrite   = 1'b0;
        i_paddr    = '0;
        i_pwdata   = '0;
        sink_wait  = 0;
        calm       = 1'b0;
        exp_wr     = 0;
        exp_rd     = 0;
        mismatches    = 0;
        results_seen  = 0;
        requests_sent = 0;
        lock_pct      = 50;
        foreach (status_seen[i]) status_seen[i] = 0;

        // Predicted state after reset.
        arb_policy = 1'b0;
        arb_lfsr   = mafr_pkg::SEED_RESET;
        arb_held   = 1'b0;
        arb_owner  = 4'd0;
        arb_count  = 0;
        foreach (arb_waiters[i]) arb_waiters[i] = 4'd0;

        // Directed table: unlock of a free mutex, lock and release, refused unlock,
        // lock by the owner, a queue filled to the brim, a drop, then FIFO handovers.
        plan[0] = '{mafr_pkg::KIND_UNLOCK, 4'd0,  1'b1,
                    '{mafr_pkg::ST_NOT_OWNER, 1'b0, 4'd0,  1'b0, 5'd0}};
        plan[1] = '{mafr_pkg::KIND_LOCK,   4'd15, 1'b1,
                    '{mafr_pkg::ST_ACQUIRED,  1'b1, 4'd15, 1'b1, 5'd0}};
        plan[2] = '{mafr_pkg::KIND_UNLOCK, 4'd15, 1'b1,
                    '{mafr_pkg::ST_RELEASED,  1'b0, 4'd0,  1'b0, 5'd0}};
        plan[3] = '{mafr_pkg::KIND_LOCK,   4'd0,  1'b1,
                    '{mafr_pkg::ST_ACQUIRED,  1'b1, 4'd0,  1'b1, 5'd0}};
        plan[4] = '{mafr_pkg::KIND_UNLOCK, 4'd9,  1'b1,
                    '{mafr_pkg::ST_NOT_OWNER, 1'b0, 4'd0,  1'b1, 5'd0}};
        plan[5] = '{mafr_pkg::KIND_LOCK,   4'd0,  1'b1,
                    '{mafr_pkg::ST_QUEUED,    1'b0, 4'd0,  1'b1, 5'd1}};
        for (int i = 0; i < 15; i++) begin
            plan[6 + i] = '{mafr_pkg::KIND_LOCK, 4'(i + 1), 1'b0, '0};
        end
        plan[21] = '{mafr_pkg::KIND_LOCK,   4'd5, 1'b1,
                     '{mafr_pkg::ST_FULL, 1'b0, 4'd0, 1'b1, 5'd16}};
        plan[22] = '{mafr_pkg::KIND_UNLOCK, 4'd0, 1'b0, '0};
        plan[23] = '{mafr_pkg::KIND_UNLOCK, 4'd0, 1'b0, '0};
        plan[24] = '{mafr_pkg::KIND_UNLOCK, 4'd1, 1'b0, '0};

        // Settings walked by the random phases, extremes of the seed among them.
        setups[0] = '{1'b1, 1'b0, 16'd0};
        setups[1] = '{1'b1, 1'b1, 16'hFFFF};
        setups[2] = '{1'b0, 1'b1, 16'h1234};
        setups[3] = '{1'b1, 1'b1, 16'd0};
        setups[4] = '{1'b1, 1'b1, 16'($urandom_range(1, 65535))};
        setups[5] = '{1'b0, 1'b0, 16'd0};
        setups[6] = '{1'b1, 1'b0, 16'd0};
        setups[7] = '{1'b1, 1'b1, 16'd1};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[n]) begin
            send_req(plan[n].kind, plan[n].who, plan[n].typed, plan[n].want);
        end

        // Random phases: bursts lean toward locks to fill the queue or toward
        // owner unlocks to drain it, with some unlocks from the wrong requester.
        for (int p = 0; p < PHASES; p++) begin
            calm = 1'b0;
            wait_idle();
            write_reg(mafr_pkg::REG_POLICY,
                      ($urandom() & ~32'd1) | {31'd0, setups[p].policy});
            if (setups[p].load_seed) begin
                write_reg(mafr_pkg::REG_SEED,
                          ($urandom() & 32'hFFFF_0000) | {16'd0, setups[p].seed});
            end
            calm = (p % 3 == 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 37 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       lock_pct = 85;
                        1:       lock_pct = 55;
                        default: lock_pct = 25;
                    endcase
                end
                if ($urandom_range(0, 99) < lock_pct) begin
                    kind = mafr_pkg::KIND_LOCK;
                    who  = 4'($urandom_range(0, 15));
                end else begin
                    kind = mafr_pkg::KIND_UNLOCK;
                    who  = (arb_held && $urandom_range(0, 3) != 0) ? arb_owner
                                                                  : 4'($urandom_range(0, 15));
                end
                send_req(kind, who, 1'b0, '0);
            end
        end

        calm = 1'b0;
        wait_idle();

        $display("Sent %0d requests over %0d register settings: %0d acquired, %0d queued,",
                 requests_sent, PHASES + 1, status_seen[mafr_pkg::ST_ACQUIRED],
                 status_seen[mafr_pkg::ST_QUEUED]);
        $display("%0d released, %0d refused unlocks, %0d dropped on a full queue; both policies.",
                 status_seen[mafr_pkg::ST_RELEASED], status_seen[mafr_pkg::ST_NOT_OWNER],
                 status_seen[mafr_pkg::ST_FULL]);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("Time limit reached with %0d results outstanding.", exp_wr - exp_rd);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
